>>> hw/rtl/dpbp_pkg.sv
// shared types and constants for the depth pixel back-projection core
package dpbp_pkg;

	// input request kinds carried on tuser
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_POSE  = 1'b1;

	// pose row code that loads nothing
	localparam logic [1:0] POSE_ROW_NONE = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_INV_FOCAL_X = 3'd0;
	localparam logic [2:0] CFG_INV_FOCAL_Y = 3'd1;
	localparam logic [2:0] CFG_CENTER_X    = 3'd2;
	localparam logic [2:0] CFG_CENTER_Y    = 3'd3;
	localparam logic [2:0] CFG_METRES_UNIT = 3'd4;
	localparam logic [2:0] CFG_MAX_DEPTH   = 3'd5;
	localparam logic [2:0] CFG_MIN_DEPTH   = 3'd6;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

	// classified request handed from front to back
	typedef struct packed {
		logic               pose;
		logic               clamped;
		logic [31:0]        depth;
		logic signed [28:0] du;
		logic signed [28:0] dv;
		logic [1:0]         sel;
		logic signed [17:0] ra;
		logic signed [17:0] rb;
		logic signed [17:0] rc;
		logic signed [31:0] offset;
	} dpbp_item_t;

	// queue status seen by front and back
	typedef struct packed {
		logic [QCW-1:0] level;
		logic           empty;
	} dpbp_qstat_t;

	// clip to the signed 32 bit range
	function automatic logic [31:0] sat32(input logic signed [67:0] v);
		logic [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -68'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/dpbp_front.sv
// front end: accepts requests, scales depth, clamps or drops, pushes to the queue
module dpbp_front #(
	parameter int COORD_BITS = 12,
	parameter int DEPTH_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// pixel_col, pixel_row, raw_depth, row_select, rot_a, rot_b, rot_c, offset
	input  logic [127:0]        s_tdata,
	// action
	input  logic                s_tuser,
	input  logic [31:0]         metres_per_unit,
	input  logic [31:0]         max_depth,
	input  logic [31:0]         min_depth,
	input  logic [27:0]         center_x,
	input  logic [27:0]         center_y,
	input  dpbp_pkg::dpbp_qstat_t qstat,
	output logic                push,
	output dpbp_pkg::dpbp_item_t push_item
);
	import dpbp_pkg::*;

	localparam logic [11:0] COL_MASK = 12'((32'd1 << COORD_BITS) - 32'd1);
	localparam logic [15:0] RAW_MASK = 16'((32'd1 << DEPTH_BITS) - 32'd1);

	logic               valid_s1;
	logic               pose_s1;
	logic               zero_s1;
	logic [47:0]        prod_s1;
	logic [11:0]        col_s1;
	logic [11:0]        row_s1;
	logic [1:0]         sel_s1;
	logic signed [17:0] ra_s1;
	logic signed [17:0] rb_s1;
	logic signed [17:0] rc_s1;
	logic signed [31:0] offset_s1;

	logic        accept;
	logic [15:0] raw_m;
	logic [31:0] depth;
	logic        clamp;
	logic        drop;

	// credit check: queue level plus the request in flight
	assign s_tready = ({1'b0, qstat.level} + {{QCW{1'b0}}, valid_s1}) < (QCW+1)'(QDEPTH);
	assign accept   = s_tvalid && s_tready;
	assign raw_m    = s_tdata[39:24] & RAW_MASK;

	// stage 1: depth scale product and captured fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pose_s1   <= (s_tuser == ACT_POSE);
			zero_s1   <= (raw_m == 16'd0);
			prod_s1   <= {32'd0, raw_m} * {16'd0, metres_per_unit};
			col_s1    <= s_tdata[11:0] & COL_MASK;
			row_s1    <= s_tdata[23:12] & COL_MASK;
			sel_s1    <= s_tdata[41:40];
			ra_s1     <= s_tdata[59:42];
			rb_s1     <= s_tdata[77:60];
			rc_s1     <= s_tdata[95:78];
			offset_s1 <= s_tdata[127:96];
		end
	end

	// depth limits
	assign depth = prod_s1[47:16];
	assign clamp = zero_s1 || (depth > max_depth);
	assign drop  = !clamp && (depth < min_depth);

	// classify and hand over
	always_comb begin
		push_item.pose    = pose_s1;
		push_item.clamped = clamp;
		push_item.depth   = clamp ? max_depth : depth;
		push_item.du      = $signed({1'b0, col_s1, 16'd0}) - $signed({1'b0, center_x});
		push_item.dv      = $signed({1'b0, row_s1, 16'd0}) - $signed({1'b0, center_y});
		push_item.sel     = sel_s1;
		push_item.ra      = ra_s1;
		push_item.rb      = rb_s1;
		push_item.rc      = rc_s1;
		push_item.offset  = offset_s1;
	end

	assign push = valid_s1 && (pose_s1 ? (sel_s1 != POSE_ROW_NONE) : !drop);

endmodule

>>> hw/rtl/dpbp_queue.sv
// short queue between front and back
module dpbp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dpbp_pkg::dpbp_item_t  push_item,
	input  logic                  pop,
	output dpbp_pkg::dpbp_item_t  head,
	output dpbp_pkg::dpbp_qstat_t qstat
);
	import dpbp_pkg::*;

	dpbp_item_t     mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] level_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			level_q <= level_q + QCW'(push) - QCW'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.level = level_q;
	assign qstat.empty = (level_q == '0);

endmodule

>>> hw/rtl/dpbp_back.sv
// back end: ray products, pose rotation and translation, saturation, output register
module dpbp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dpbp_pkg::dpbp_item_t  head,
	input  dpbp_pkg::dpbp_qstat_t qstat,
	output logic                  pop,
	input  logic [31:0]           inv_focal_x,
	input  logic [31:0]           inv_focal_y,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// world_x, world_y, world_z
	output logic [95:0]           m_tdata,
	// was_clamped
	output logic                  m_tuser
);
	import dpbp_pkg::*;

	logic en;

	// stage 1
	logic               valid_s1;
	dpbp_item_t         item_s1;
	logic signed [61:0] px_s1;
	logic signed [61:0] py_s1;
	// stage 2
	logic               valid_s2;
	dpbp_item_t         item_s2;
	logic signed [62:0] qx_s2;
	logic signed [62:0] qy_s2;
	// stage 3
	logic               valid_s3;
	logic               clamped_s3;
	logic signed [65:0] pr_s3 [3][3];
	logic signed [31:0] pos_s3 [3];
	// stage 4
	logic               valid_s4;
	logic               clamped_s4;
	logic signed [66:0] acc_s4 [3];
	logic signed [31:0] pos_s4 [3];
	// output register
	logic               out_valid_q;
	logic               out_clamped_q;
	logic [31:0]        world_q [3];

	// pose state
	logic signed [17:0] rot_q [3][3];
	logic signed [31:0] pos_q [3];

	logic signed [29:0] ray_x;
	logic signed [29:0] ray_y;
	logic signed [47:0] cam [3];
	logic signed [65:0] pr [3][3];
	logic signed [67:0] wsum [3];

	// whole pipeline moves unless the output is stalled
	assign en  = !out_valid_q || m_tready;
	assign pop = en && !qstat.empty;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2 && !item_s2.pose;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	// ray slope products
	assign ray_x = 30'(px_s1 >>> 32);
	assign ray_y = 30'(py_s1 >>> 32);

	// camera frame coordinates
	always_comb begin
		cam[0] = 48'($signed({1'b0, item_s2.depth}));
		cam[1] = -48'(qx_s2 >>> 16);
		cam[2] = -48'(qy_s2 >>> 16);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				pr[i][j] = rot_q[i][j] * cam[j];
			end
		end
	end

	// data path stages
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1       <= head;
			px_s1         <= head.du * $signed({1'b0, inv_focal_x});
			py_s1         <= head.dv * $signed({1'b0, inv_focal_y});
			item_s2       <= item_s1;
			qx_s2         <= ray_x * $signed({1'b0, item_s1.depth});
			qy_s2         <= ray_y * $signed({1'b0, item_s1.depth});
			clamped_s3    <= item_s2.clamped;
			pr_s3         <= pr;
			pos_s3        <= pos_q;
			clamped_s4    <= clamped_s3;
			pos_s4        <= pos_s3;
			for (int i = 0; i < 3; i++) begin
				acc_s4[i] <= 67'(pr_s3[i][0]) + 67'(pr_s3[i][1]) + 67'(pr_s3[i][2]);
			end
			out_clamped_q <= clamped_s4;
			for (int i = 0; i < 3; i++) begin
				world_q[i] <= sat32(wsum[i]);
			end
		end
	end

	// pose load takes effect in order with pixels at the rotation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					rot_q[i][j] <= (i == j) ? 18'sd65536 : 18'sd0;
				end
				pos_q[i] <= '0;
			end
		end else if (en && valid_s2 && item_s2.pose) begin
			rot_q[item_s2.sel][0] <= item_s2.ra;
			rot_q[item_s2.sel][1] <= item_s2.rb;
			rot_q[item_s2.sel][2] <= item_s2.rc;
			pos_q[item_s2.sel]    <= item_s2.offset;
		end
	end

	// translate before saturation
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wsum[i] = 68'(acc_s4[i] >>> 16) + 68'(pos_s4[i]);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {world_q[2], world_q[1], world_q[0]};
	assign m_tuser  = out_clamped_q;

endmodule

>>> hw/rtl/depth_pixel_back_projection_core.sv
// top level of the depth pixel back-projection core
// Turns a stream of depth pixels into world points through a pinhole camera and a
// loadable pose. One request (pixel or pose row) is taken per clock when the output
// keeps up; an accepted pixel passes through one front stage (loaded at the accepting
// edge), the queue, four back stages and the output register. The front stage scales
// and clamps depth and drops near pixels; a four-entry queue decouples it from the
// back pipeline, which makes one pass per cycle through its multiplier stages unless
// the output stalls. Pose rows take effect for every pixel that follows them in the
// stream. The user must write configuration through cfg_we, cfg_addr and cfg_wdata
// only while the core is idle; the core itself does not enforce this.
module depth_pixel_back_projection_core #(
	parameter int COORD_BITS = 12,
	parameter int DEPTH_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pixel_col, pixel_row, raw_depth, row_select, rot_a, rot_b, rot_c, offset
	input  logic [127:0] s_tdata,
	// action
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// world_x, world_y, world_z
	output logic [95:0]  m_tdata,
	// was_clamped
	output logic         m_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [31:0]  cfg_wdata
);
	import dpbp_pkg::*;

	logic [31:0] inv_focal_x_q;
	logic [31:0] inv_focal_y_q;
	logic [27:0] center_x_q;
	logic [27:0] center_y_q;
	logic [31:0] metres_per_unit_q;
	logic [31:0] max_depth_q;
	logic [31:0] min_depth_q;

	logic        push;
	logic        pop;
	dpbp_item_t  push_item;
	dpbp_item_t  head;
	dpbp_qstat_t qstat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_focal_x_q     <= 32'd11098;
			inv_focal_y_q     <= 32'd11098;
			center_x_q        <= 28'd21039850;
			center_y_q        <= 28'd15955968;
			metres_per_unit_q <= 32'd4294967;
			max_depth_q       <= 32'd327680;
			min_depth_q       <= 32'd13107;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_INV_FOCAL_X: inv_focal_x_q     <= cfg_wdata;
				CFG_INV_FOCAL_Y: inv_focal_y_q     <= cfg_wdata;
				CFG_CENTER_X:    center_x_q        <= cfg_wdata[27:0];
				CFG_CENTER_Y:    center_y_q        <= cfg_wdata[27:0];
				CFG_METRES_UNIT: metres_per_unit_q <= cfg_wdata;
				CFG_MAX_DEPTH:   max_depth_q       <= cfg_wdata;
				CFG_MIN_DEPTH:   min_depth_q       <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// front end
	dpbp_front #(
		.COORD_BITS(COORD_BITS),
		.DEPTH_BITS(DEPTH_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.metres_per_unit(metres_per_unit_q),
		.max_depth(max_depth_q),
		.min_depth(min_depth_q),
		.center_x(center_x_q),
		.center_y(center_y_q),
		.qstat(qstat),
		.push(push),
		.push_item(push_item)
	);

	// decoupling queue
	dpbp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head(head),
		.qstat(qstat)
	);

	// back end
	dpbp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.qstat(qstat),
		.pop(pop),
		.inv_focal_x(inv_focal_x_q),
		.inv_focal_y(inv_focal_y_q),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (qstat.level != QCW'(QDEPTH)))
		else $error("push into a full queue");

	// back end never reads an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from an empty queue");

	// fill level stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		qstat.level <= QCW'(QDEPTH))
		else $error("queue level out of range");

endmodule
